// ===== hw/rtl/lsdh_pkg.sv =====
// ----------------------------------------------------------------------------
// lsdh_pkg
// Shared constants for the rangefinder deframer and height converter.
// ----------------------------------------------------------------------------
package lsdh_pkg;

  // sync pattern starts at this byte and counts up by one per matched byte
  localparam logic [7:0] SyncFirst = 8'hFC;
  localparam logic [1:0] SyncLast  = 2'd3;

  // fixed point constants for the cosine table
  localparam logic [63:0] OneQ32 = 64'h1_0000_0000;
  localparam logic [63:0] PiQ32  = 64'h3_243F_6A89;
  localparam logic [63:0] Half16 = 64'd32768;
  localparam logic [63:0] MaxQ16 = 64'd65535;

  // taylor series denominators, innermost term first
  localparam logic [63:0] CosDen [6] = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};

  // stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 72;

  // result fields
  typedef struct packed {
    logic [15:0] packet_number;
    logic [7:0]  plane_id;
    logic [8:0]  point_index;
    logic [15:0] distance;
    logic [15:0] height;
  } point_t;

endpackage

// ===== hw/rtl/laser_scan_deframe_height.sv =====
// ----------------------------------------------------------------------------
// laser_scan_deframe_height
// Deframes a rangefinder byte stream and turns each distance into a height.
// ----------------------------------------------------------------------------
// The block takes one received byte per transfer and accepts a byte on every
// clock while the result register is empty or being drained. It hunts for
// the sync bytes FC FD FE FF, reads a little-endian 16-bit payload length and
// then walks the payload. The byte at payload offset FIRST_PLANE_OFFSET is
// the plane number of the first block, followed by POINTS little-endian
// distances; SECOND_PLANE_OFFSET starts the second block the same way. For
// each distance, one result appears on the master side the cycle after its
// high byte is transferred: height = (distance * cos(angle)) >> 16, with the
// beam angle running from -48 to +48 degrees across the block. The cosine
// comes from a constant table that is read when the low byte arrives, so the
// multiply sits alone between that register and the result register. Sync is
// only searched for between payloads; points or plane bytes beyond a short
// payload are simply never seen. Throughput is one byte per clock; the input
// stalls only while a result waits in the output register and the master
// side is not ready.
module laser_scan_deframe_height #(
  parameter int unsigned POINTS              = 274,
  parameter int unsigned FIRST_PLANE_OFFSET  = 8,
  parameter int unsigned SECOND_PLANE_OFFSET = 1655
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side: one received byte per transfer
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lsdh_pkg::InDataW-1:0]   s_axis_tdata,  // [7:0] rx_byte
  // master side: one point per transfer
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] height, [31:16] distance, [40:32] point_index, [48:41] plane_id,
  // [64:49] packet_number, [71:65] zero
  output logic [lsdh_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tuser,  // [0] block_select
  output logic                           m_axis_tlast   // last_point
);

  localparam int unsigned KW    = $clog2(POINTS);
  localparam int unsigned PadW  = lsdh_pkg::OutDataW - $bits(lsdh_pkg::point_t);

  typedef enum logic [1:0] {
    PhHunt,
    PhLenLo,
    PhLenHi,
    PhPayload
  } phase_e;

  // --------------------------------------------------------------------------
  // cosine table, worked out at elaboration
  // entry i is cos(-48 + 96*i/(POINTS-1) degrees) in unsigned Q0.16, from a
  // six term series on the squared angle
  // --------------------------------------------------------------------------
  logic [15:0] cos_rom [POINTS];

  for (genvar gi = 0; gi < POINTS; gi++) begin : g_cos
    localparam logic [63:0] Span  = 64'(POINTS - 1);
    localparam logic [63:0] Twice = 64'(2 * gi);
    localparam logic [63:0] Dev   = (Twice > Span) ? (Twice - Span) : (Span - Twice);
    localparam logic [63:0] X     = (Dev * 64'd4 * lsdh_pkg::PiQ32) / (64'd15 * Span);
    localparam logic [63:0] X2    = (X * X) >> 32;
    localparam logic [63:0] T1 = lsdh_pkg::OneQ32
                                 - ((X2 * lsdh_pkg::OneQ32) >> 32) / lsdh_pkg::CosDen[0];
    localparam logic [63:0] T2 = lsdh_pkg::OneQ32 - ((X2 * T1) >> 32) / lsdh_pkg::CosDen[1];
    localparam logic [63:0] T3 = lsdh_pkg::OneQ32 - ((X2 * T2) >> 32) / lsdh_pkg::CosDen[2];
    localparam logic [63:0] T4 = lsdh_pkg::OneQ32 - ((X2 * T3) >> 32) / lsdh_pkg::CosDen[3];
    localparam logic [63:0] T5 = lsdh_pkg::OneQ32 - ((X2 * T4) >> 32) / lsdh_pkg::CosDen[4];
    localparam logic [63:0] T6 = lsdh_pkg::OneQ32 - ((X2 * T5) >> 32) / lsdh_pkg::CosDen[5];
    localparam logic [63:0] Rnd   = (T6 + lsdh_pkg::Half16) >> 16;
    localparam logic [63:0] Entry = (Rnd > lsdh_pkg::MaxQ16) ? lsdh_pkg::MaxQ16 : Rnd;
    assign cos_rom[gi] = Entry[15:0];
  end

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  phase_e      phase_q;
  logic [1:0]  sync_cnt_q;     // sync bytes matched so far
  logic [7:0]  len_lo_q;
  logic [15:0] remain_q;       // payload bytes still to come
  logic [15:0] offset_q;       // offset of the next payload byte
  logic [7:0]  low_q;          // low byte of the distance in flight
  logic [15:0] cos_q;          // table entry for the distance in flight
  logic [7:0]  plane_q;
  logic [15:0] pkt_cnt_q;

  // result register
  logic                  out_valid_q;
  lsdh_pkg::point_t      out_q;
  logic                  out_blk_q;
  logic                  out_last_q;
  logic [KW-1:0]         out_k_q;

  // --------------------------------------------------------------------------
  // handshake: the result register frees up in the same cycle it drains
  // --------------------------------------------------------------------------
  logic accept;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [7:0] rx_byte;
  assign rx_byte = s_axis_tdata;

  // --------------------------------------------------------------------------
  // payload offset decode
  // --------------------------------------------------------------------------
  logic [16:0]   d0, d1;
  logic          in_b0, in_b1, in_span, sel_b1;
  logic [15:0]   rel_d;        // offset from the plane byte of the block
  logic [15:0]   rel;          // offset from the first distance byte
  logic          is_plane, is_low;
  logic [KW-1:0] k;
  logic [15:0]   point_dist;
  logic [31:0]   product;
  logic          emit;

  always_comb begin
    d0         = {1'b0, offset_q} - 17'(FIRST_PLANE_OFFSET);
    d1         = {1'b0, offset_q} - 17'(SECOND_PLANE_OFFSET);
    in_b0      = !d0[16] && (d0[15:0] <= 16'(2 * POINTS));
    in_b1      = !d1[16] && (d1[15:0] <= 16'(2 * POINTS));
    // the first block wins where the two overlap
    sel_b1     = !in_b0 && in_b1;
    in_span    = in_b0 || in_b1;
    rel_d      = sel_b1 ? d1[15:0] : d0[15:0];
    is_plane   = (rel_d == '0);
    rel        = rel_d - 16'd1;
    is_low     = !rel[0];
    k          = KW'(rel >> 1);
    point_dist = {rx_byte, low_q};
    product    = point_dist * cos_q;
    emit       = accept && (phase_q == PhPayload) && in_span && !is_plane && !is_low;
  end

  // --------------------------------------------------------------------------
  // framing state and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      sync_cnt_q  <= '0;
      len_lo_q    <= '0;
      remain_q    <= '0;
      offset_q    <= '0;
      low_q       <= '0;
      cos_q       <= '0;
      plane_q     <= '0;
      pkt_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      out_blk_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_k_q     <= '0;
    end else begin
      if (accept) begin
        case (phase_q)
          PhHunt: begin
            if (rx_byte == lsdh_pkg::SyncFirst + 8'(sync_cnt_q)) begin
              if (sync_cnt_q == lsdh_pkg::SyncLast) begin
                sync_cnt_q <= '0;
                pkt_cnt_q  <= pkt_cnt_q + 16'd1;
                phase_q    <= PhLenLo;
              end else begin
                sync_cnt_q <= sync_cnt_q + 2'd1;
              end
            end else begin
              // a stray FC may be the start of a fresh sync
              sync_cnt_q <= (rx_byte == lsdh_pkg::SyncFirst) ? 2'd1 : 2'd0;
            end
          end
          PhLenLo: begin
            len_lo_q <= rx_byte;
            phase_q  <= PhLenHi;
          end
          PhLenHi: begin
            remain_q <= {rx_byte, len_lo_q};
            offset_q <= '0;
            // an empty payload goes straight back to hunting
            phase_q  <= ({rx_byte, len_lo_q} == '0) ? PhHunt : PhPayload;
          end
          PhPayload: begin
            if (in_span) begin
              if (is_plane) begin
                plane_q <= rx_byte;
              end else if (is_low) begin
                low_q <= rx_byte;
                cos_q <= cos_rom[k];
              end
            end
            offset_q <= offset_q + 16'd1;
            remain_q <= remain_q - 16'd1;
            if (remain_q == 16'd1) begin
              phase_q    <= PhHunt;
              sync_cnt_q <= '0;
            end
          end
          default: begin
            phase_q <= PhHunt;
          end
        endcase
      end

      // result register: load on a high byte, else drain on transfer
      if (emit) begin
        out_valid_q         <= 1'b1;
        out_q.height        <= product[31:16];
        out_q.distance      <= point_dist;
        out_q.point_index   <= 9'(k);
        out_q.plane_id      <= plane_q;
        out_q.packet_number <= pkt_cnt_q;
        out_blk_q           <= sel_b1;
        out_last_q          <= sel_b1 && (k == KW'(POINTS - 1));
        out_k_q             <= k;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_q};
  assign m_axis_tuser  = out_blk_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // a payload in progress always has bytes left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (remain_q != '0))
    else $error("payload phase with no bytes remaining");

  // partial sync only while hunting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhHunt) |-> (sync_cnt_q == '0))
    else $error("sync progress outside hunt phase");

  // a new result only comes out of a payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(phase_q) == PhPayload))
    else $error("result raised outside a payload");

  // beam index stays within the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_k_q <= KW'(POINTS - 1)))
    else $error("point index beyond the block");

  // the final point only belongs to the second block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("last point flagged in the first block");
`endif

endmodule

// ===== verif/laser_scan_deframe_height_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_scan_deframe_height_tb
// Self-checking bench for the rangefinder deframer and height converter.
// ----------------------------------------------------------------------------
// A short table of bytes walks the sync hunter, the length bytes, a sync
// pattern buried in a payload, the plane byte and a payload cut short inside
// a point. One full length packet then covers both blocks and the final
// point, and a short random tail follows: short payloads, zero length
// packets, broken sync attempts and line noise. Every accepted byte goes
// through a local model of the framer; each point on the master side is
// compared field by field with the oldest predicted point. Both sides idle
// at random, with stretches where they run flat out.
module laser_scan_deframe_height_tb;

  localparam int unsigned Points            = 274;
  localparam int unsigned FirstPlaneOffset  = 8;
  localparam int unsigned SecondPlaneOffset = 1655;
  localparam int unsigned FullLength        = SecondPlaneOffset + 2 * Points + 1;
  localparam int unsigned DirRows           = 22;
  localparam int unsigned StallLimit        = 2000;
  localparam int unsigned RandEvents        = 30;
  localparam int unsigned MaxShown          = 10;

  typedef enum logic [1:0] {
    HuntSync,
    LengthLow,
    LengthHigh,
    InPayload
  } frame_phase_e;

  // one predicted or observed height point
  typedef struct packed {
    lsdh_pkg::point_t pt;
    logic             blk;
    logic             last;
  } height_rec_t;

  // one row of the directed byte table
  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    height_rec_t want;
  } dir_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [lsdh_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [lsdh_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;

  laser_scan_deframe_height #(
    .POINTS              (Points),
    .FIRST_PLANE_OFFSET  (FirstPlaneOffset),
    .SECOND_PLANE_OFFSET (SecondPlaneOffset)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [15:0] height, [31:16] distance, [40:32] point_index, [48:41] plane_id,
    // [64:49] packet_number, [71:65] zero
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),   // [0] block_select
    .m_axis_tlast  (m_axis_tlast)    // last_point
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // framer model state
  frame_phase_e phase;
  logic [2:0]   sync_cnt;
  logic [7:0]   len_lo;
  logic [15:0]  remain;
  logic [15:0]  offset;
  logic [7:0]   dist_lo;
  logic [7:0]   plane;
  logic [15:0]  pkt_cnt;
  logic [15:0]  cos_table [Points];

  height_rec_t  pending_heights [$];
  bit           no_gaps = 1'b0;
  int unsigned  bytes_counted = 0;
  int unsigned  points_seen = 0;
  int unsigned  last_seen = 0;
  int unsigned  mismatch_cnt = 0;

  // taylor denominators, innermost term first
  function automatic logic [63:0] taylor_den(int unsigned k);
    case (k)
      0: return 64'd132;
      1: return 64'd90;
      2: return 64'd56;
      3: return 64'd30;
      4: return 64'd12;
      default: return 64'd2;
    endcase
  endfunction

  // cosine of the beam angle of entry i as unsigned q0.16
  function automatic logic [15:0] beam_cosine(int unsigned i);
    logic [63:0] span, twice, dev, x, x2, t, r;
    span  = 64'(Points - 1);
    twice = 64'(2 * i);
    dev   = (twice > span) ? twice - span : span - twice;
    x     = dev * 64'd4 * lsdh_pkg::PiQ32 / (64'd15 * span);
    x2    = (x * x) >> 32;
    t     = lsdh_pkg::OneQ32;
    for (int unsigned k = 0; k < 6; k++) begin
      t = lsdh_pkg::OneQ32 - ((x2 * t) >> 32) / taylor_den(k);
    end
    r = (t + lsdh_pkg::Half16) >> 16;
    return (r > lsdh_pkg::MaxQ16) ? 16'hFFFF : r[15:0];
  endfunction

  // advance the framer model by one accepted byte
  task automatic deframe_step(input logic [7:0] b, output bit got, output height_rec_t rec);
    int unsigned o, base, rel;
    bit          in_blk;
    logic        blk;
    logic [15:0] point_dist;
    logic [31:0] prod;
    got    = 1'b0;
    rec    = '0;
    in_blk = 1'b0;
    blk    = 1'b0;
    base   = 0;
    case (phase)
      HuntSync: begin
        if (b == lsdh_pkg::SyncFirst + 8'(sync_cnt)) begin
          sync_cnt = sync_cnt + 3'd1;
          if (sync_cnt == 3'd4) begin
            sync_cnt = '0;
            pkt_cnt  = pkt_cnt + 16'd1;
            phase    = LengthLow;
          end
        end else begin
          // a stray first sync byte restarts the match at one
          sync_cnt = (b == lsdh_pkg::SyncFirst) ? 3'd1 : 3'd0;
        end
      end
      LengthLow: begin
        len_lo = b;
        phase  = LengthHigh;
      end
      LengthHigh: begin
        remain = {b, len_lo};
        offset = '0;
        phase  = (remain == 16'd0) ? HuntSync : InPayload;
      end
      default: begin
        o = offset;
        // the first block wins where the two spans overlap
        if (o >= FirstPlaneOffset && o - FirstPlaneOffset <= 2 * Points) begin
          in_blk = 1'b1;
          base   = FirstPlaneOffset;
        end else if (o >= SecondPlaneOffset && o - SecondPlaneOffset <= 2 * Points) begin
          in_blk = 1'b1;
          base   = SecondPlaneOffset;
          blk    = 1'b1;
        end
        if (in_blk) begin
          if (o == base) begin
            plane = b;
          end else begin
            rel = o - base - 1;
            if (rel[0] == 1'b0) begin
              dist_lo = b;
            end else begin
              point_dist           = {b, dist_lo};
              prod                 = 32'(point_dist) * 32'(cos_table[rel >> 1]);
              got                  = 1'b1;
              rec.pt.height        = prod[31:16];
              rec.pt.distance      = point_dist;
              rec.pt.point_index   = 9'(rel >> 1);
              rec.pt.plane_id      = plane;
              rec.pt.packet_number = pkt_cnt;
              rec.blk              = blk;
              rec.last             = blk && ((rel >> 1) == Points - 1);
            end
          end
        end
        offset = offset + 16'd1;
        remain = remain - 16'd1;
        if (remain == 16'd0) begin
          phase    = HuntSync;
          sync_cnt = '0;
        end
      end
    endcase
  endtask

  // one slave-side transfer, with a random gap ahead of it
  task automatic push_byte(input logic [7:0] b, input bit use_want, input height_rec_t want);
    int unsigned gap;
    bit          got;
    height_rec_t rec;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_counted++;
    deframe_step(b, got, rec);
    if (got) begin
      pending_heights.push_back(use_want ? want : rec);
    end
  endtask

  task automatic send(input logic [7:0] b);
    push_byte(b, 1'b0, '0);
  endtask

  task automatic send_sync();
    for (int unsigned i = 0; i < 4; i++) begin
      send(lsdh_pkg::SyncFirst + 8'(i));
    end
  endtask

  // payload bytes lean on the distance extremes
  function automatic logic [7:0] payload_draw();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_packet(input logic [15:0] len);
    int unsigned off;
    send_sync();
    send(len[7:0]);
    send(len[15:8]);
    off = 0;
    while (off < len) begin
      // now and then a sync pattern inside the payload, which must be ignored
      if ($urandom_range(0, 199) == 0 && off + 4 <= len) begin
        send_sync();
        off += 4;
      end else begin
        send(payload_draw());
        off++;
      end
    end
  endtask

  // partial sync followed by a wrong byte
  task automatic send_broken_sync();
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(1, 3);
    for (int unsigned i = 0; i < n; i++) begin
      send(lsdh_pkg::SyncFirst + 8'(i));
    end
    b = 8'($urandom_range(0, 255));
    if (b == lsdh_pkg::SyncFirst + 8'(n)) b = b ^ 8'h01;
    send(b);
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 12);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        send(lsdh_pkg::SyncFirst + 8'($urandom_range(0, 3)));
      end else begin
        send(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // directed bytes; only the zero distance point is typed in
  function automatic dir_row_t dir_row(int unsigned i);
    dir_row_t r;
    r = '0;
    case (i)
      0:  r.rx = lsdh_pkg::SyncFirst;
      1:  r.rx = 8'h00;                        // mismatch, back to zero
      2:  r.rx = lsdh_pkg::SyncFirst;
      3:  r.rx = lsdh_pkg::SyncFirst + 8'd1;
      4:  r.rx = lsdh_pkg::SyncFirst;          // mismatch on a first sync byte
      5:  r.rx = lsdh_pkg::SyncFirst + 8'd1;
      6:  r.rx = lsdh_pkg::SyncFirst + 8'd2;
      7:  r.rx = lsdh_pkg::SyncFirst + 8'd3;   // packet 1
      8:  r.rx = 8'd12;                        // length ends inside the second point
      9:  r.rx = 8'd0;
      10: r.rx = lsdh_pkg::SyncFirst;          // sync pattern inside the payload
      11: r.rx = lsdh_pkg::SyncFirst + 8'd1;
      12: r.rx = lsdh_pkg::SyncFirst + 8'd2;
      13: r.rx = lsdh_pkg::SyncFirst + 8'd3;
      14: r.rx = 8'h00;
      15: r.rx = 8'hFF;
      16: r.rx = 8'h55;
      17: r.rx = 8'hAA;
      18: r.rx = 8'hFF;                        // plane byte
      19: r.rx = 8'h00;
      20: begin
        r.rx                      = 8'h00;     // zero distance gives zero height
        r.typed                   = 1'b1;
        r.want.pt.plane_id        = 8'hFF;
        r.want.pt.packet_number   = 16'd1;
      end
      default: r.rx = 8'hFF;                   // low byte only, never emitted
    endcase
    return r;
  endfunction

  // master side: random stall ahead of each transfer, then check it
  initial begin : receiver
    int unsigned gap;
    height_rec_t got, want;
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.pt   = m_axis_tdata[64:0];
      got.blk  = m_axis_tuser;
      got.last = m_axis_tlast;
      points_seen++;
      if (got.last) last_seen++;
      if (pending_heights.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxShown) begin
          $display("unexpected point: h=%h d=%h k=%0d plane=%h blk=%b pkt=%h last=%b",
                   got.pt.height, got.pt.distance, got.pt.point_index, got.pt.plane_id,
                   got.blk, got.pt.packet_number, got.last);
        end
      end else begin
        want = pending_heights.pop_front();
        if (got.pt.height !== want.pt.height || got.pt.distance !== want.pt.distance ||
            got.pt.point_index !== want.pt.point_index ||
            got.pt.plane_id !== want.pt.plane_id ||
            got.pt.packet_number !== want.pt.packet_number ||
            got.blk !== want.blk || got.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxShown) begin
            $display("point mismatch exp: h=%h d=%h k=%0d plane=%h blk=%b pkt=%h last=%b",
                     want.pt.height, want.pt.distance, want.pt.point_index,
                     want.pt.plane_id, want.blk, want.pt.packet_number, want.last);
            $display("               got: h=%h d=%h k=%0d plane=%h blk=%b pkt=%h last=%b",
                     got.pt.height, got.pt.distance, got.pt.point_index,
                     got.pt.plane_id, got.blk, got.pt.packet_number, got.last);
          end
        end
      end
    end
  end

  // ends the run when transfers stop on both sides
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no transfer for %0d cycles, %0d points still pending",
             StallLimit, pending_heights.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    dir_row_t    row;
    int unsigned pkts, r;
    for (int unsigned i = 0; i < Points; i++) begin
      cos_table[i] = beam_cosine(i);
    end
    phase    = HuntSync;
    sync_cnt = '0;
    len_lo   = '0;
    remain   = '0;
    offset   = '0;
    dist_lo  = '0;
    plane    = '0;
    pkt_cnt  = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < DirRows; i++) begin
      row = dir_row(i);
      push_byte(row.rx, row.typed, row.want);
    end

    // one full payload reaches both blocks and the final point
    no_gaps = ($urandom_range(0, 1) == 0);
    send_packet(16'(FullLength));
    pkts = 1;
    while (pkts < RandEvents) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_packet(16'($urandom_range(0, 24)));
      end else if (r < 43) begin
        // payload cut somewhere inside or just past the end of the first block
        send_packet(16'($urandom_range(9, 2 * Points + FirstPlaneOffset + 4)));
      end else if (r < 57) begin
        send_packet(16'd0);
      end else if (r < 77) begin
        send_broken_sync();
      end else begin
        send_noise();
      end
      pkts++;
    end

    no_gaps = 1'b0;
    for (int unsigned i = 0; i < 3; i++) begin
      send_packet(16'($urandom_range(11, 20)));
    end

    s_axis_tvalid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("sent %0d bytes over %0d packets and noise bursts, %0d packets synced",
             bytes_counted, pkts, pkt_cnt);
    $display("checked %0d height points, %0d block ends, %0d mismatches",
             points_seen, last_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_heights.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
